// ===== hdl/sbc_pkg.sv =====
// Package for the stereo bit crusher: sizes, register indexes, sequencer
// states and the control bundle passed from the sequencer to the datapath.
// No dependencies.
package sbc_pkg;

	localparam int SAMPLE_WIDTH    = 16;
	localparam int PHASE_FRAC_BITS = 16;
	localparam int CTRL_WIDTH      = 16;   // drive and mix, Q0.16
	localparam int DEPTH_WIDTH     = 5;
	localparam int GAIN_WIDTH      = CTRL_WIDTH + 2;   // 1 + 3*drive, Q2.16
	localparam int OPA_WIDTH       = SAMPLE_WIDTH + 1; // sample or difference
	localparam int OPB_WIDTH       = GAIN_WIDTH + 1;   // signed view of gain/mix
	localparam int PROD_WIDTH      = OPA_WIDTH + OPB_WIDTH;
	localparam int QUOT_WIDTH      = PROD_WIDTH - CTRL_WIDTH;
	localparam int SHIFT_WIDTH     = 6;
	localparam int QBITS_MAX       = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
	localparam int CFG_WIDTH       = (PHASE_FRAC_BITS + 1 > CTRL_WIDTH) ?
	                                 PHASE_FRAC_BITS + 1 : CTRL_WIDTH;
	localparam int CFG_IDX_WIDTH   = 2;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_BIT_DEPTH  = 2'd0,
		CFG_PHASE_STEP = 2'd1,
		CFG_DRIVE      = 2'd2,
		CFG_MIX        = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_L,
		ST_CRUSH_L,
		ST_MUL_R,
		ST_CRUSH_R,
		ST_FADE_L,
		ST_FIN_L,
		ST_FADE_R,
		ST_FIN_R
	} sbc_state_t;

	typedef enum logic [1:0] {
		OP_DRIVE_L,
		OP_DRIVE_R,
		OP_FADE_L,
		OP_FADE_R
	} mul_op_t;

	typedef struct packed {
		logic    mul_en;
		mul_op_t mul_op;
		logic    crush_l;
		logic    crush_r;
		logic    fin_l;
		logic    fin_r;
	} sbc_ctrl_t;

endpackage

// ===== hdl/sbc_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on sbc_pkg.
module sbc_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [sbc_pkg::OPA_WIDTH-1:0]  a,
	input  logic signed [sbc_pkg::OPB_WIDTH-1:0]  b,
	output logic signed [sbc_pkg::PROD_WIDTH-1:0] prod
);
	import sbc_pkg::*;

	logic signed [PROD_WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

// ===== hdl/sbc_seq.sv =====
// Sequencer: walks one stereo pair through the shared multiplier and the
// crush / crossfade steps. Depends on sbc_pkg.
module sbc_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	output logic               busy,
	output sbc_pkg::sbc_ctrl_t ctrl
);
	import sbc_pkg::*;

	sbc_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_nxt = ST_MUL_L;
			ST_MUL_L:   state_nxt = ST_CRUSH_L;
			ST_CRUSH_L: state_nxt = ST_MUL_R;
			ST_MUL_R:   state_nxt = ST_CRUSH_R;
			ST_CRUSH_R: state_nxt = ST_FADE_L;
			ST_FADE_L:  state_nxt = ST_FIN_L;
			ST_FIN_L:   state_nxt = ST_FADE_R;
			ST_FADE_R:  state_nxt = ST_FIN_R;
			ST_FIN_R:   if (out_free) state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_op = OP_DRIVE_L;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_MUL_L: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_DRIVE_L;
			end
			ST_CRUSH_L: ctrl.crush_l = 1'b1;
			ST_MUL_R: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_DRIVE_R;
			end
			ST_CRUSH_R: ctrl.crush_r = 1'b1;
			ST_FADE_L: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_FADE_L;
			end
			ST_FIN_L: ctrl.fin_l = 1'b1;
			ST_FADE_R: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_op = OP_FADE_R;
			end
			ST_FIN_R: ctrl.fin_r = out_free;
			default: ctrl.mul_en = 1'b0;
		endcase
	end

endmodule

// ===== hdl/stereo_bitcrusher_top.sv =====
// Stereo bit crusher top level: config registers, phase accumulator, hold
// registers, crush and crossfade datapath, output register.
// Depends on sbc_pkg, sbc_mul and sbc_seq.
//
// Usage
//  - Input beat: left_in / right_in (signed Q1.15) taken when in_valid is high
//    and in_stall low. in_stall is high while a pair is being worked on.
//  - Output beat: left_out / right_out held in an output register, offered
//    with out_valid until taken (out_valid high, out_stall low).
//  - Result registered after eight sequencer steps following acceptance; a
//    new pair is accepted only once the sequencer is back in idle. The
//    shared multiplier runs four times (drive L/R, fade L/R), each run
//    followed by one step that consumes its product.
//  - A new pair is accepted as soon as the sequencer is idle, even while the
//    previous result still waits in the output register. If the receiver
//    stalls, the last sequencer step waits for the output register to free.
//  - Reset (arst_n low) clears phase, held samples and the output valid, and
//    loads bit_depth 16, phase_step 1.0, drive 0, mix 65535.
//  - Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are
//    expected only while the block is idle.
module stereo_bitcrusher_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [sbc_pkg::SAMPLE_WIDTH-1:0] left_in,
	input  logic signed [sbc_pkg::SAMPLE_WIDTH-1:0] right_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [sbc_pkg::SAMPLE_WIDTH-1:0] left_out,
	output logic signed [sbc_pkg::SAMPLE_WIDTH-1:0] right_out,
	input  logic                                   cfg_we,
	input  logic [sbc_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
	input  logic [sbc_pkg::CFG_WIDTH-1:0]           cfg_data
);
	import sbc_pkg::*;

	localparam logic [PHASE_FRAC_BITS:0] PHASE_ONE = (PHASE_FRAC_BITS+1)'(1) << PHASE_FRAC_BITS;
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// Config registers; gain is precomputed on a drive write
	logic [DEPTH_WIDTH-1:0]     bit_depth_q;
	logic [PHASE_FRAC_BITS:0]   phase_step_q;
	logic [CTRL_WIDTH-1:0]      mix_q;
	logic [GAIN_WIDTH-1:0]      gain_q;
	logic [CTRL_WIDTH-1:0]      drive_w;
	logic [GAIN_WIDTH-1:0]      gain_w;

	always_comb begin
		drive_w = cfg_data[CTRL_WIDTH-1:0];
		gain_w  = (GAIN_WIDTH'(1) << CTRL_WIDTH) + GAIN_WIDTH'(drive_w)
		        + (GAIN_WIDTH'(drive_w) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q  <= DEPTH_WIDTH'(16);
			phase_step_q <= PHASE_ONE;
			gain_q       <= GAIN_WIDTH'(1) << CTRL_WIDTH;
			mix_q        <= '1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BIT_DEPTH:  bit_depth_q  <= cfg_data[DEPTH_WIDTH-1:0];
				CFG_PHASE_STEP: phase_step_q <= cfg_data[PHASE_FRAC_BITS:0];
				CFG_DRIVE:      gain_q       <= gain_w;
				CFG_MIX:        mix_q        <= cfg_data[CTRL_WIDTH-1:0];
				default:        mix_q        <= mix_q;
			endcase
		end
	end

	// Sequencer
	sbc_ctrl_t ctrl;
	logic      busy;
	logic      out_free;
	logic      in_acc;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = busy;
	assign in_acc   = in_valid && !busy;

	sbc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	// Input capture and phase accumulator (step saturates at 1.0)
	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;
	logic [PHASE_FRAC_BITS-1:0]     phase_q;
	logic                           hold_q;
	logic [PHASE_FRAC_BITS:0]       step_eff;
	logic [PHASE_FRAC_BITS:0]       phase_sum;

	assign step_eff  = (phase_step_q > PHASE_ONE) ? PHASE_ONE : phase_step_q;
	assign phase_sum = {1'b0, phase_q} + step_eff;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_q  <= left_in;
			right_q <= right_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			hold_q  <= 1'b0;
		end else if (in_acc) begin
			phase_q <= phase_sum[PHASE_FRAC_BITS-1:0];
			hold_q  <= phase_sum[PHASE_FRAC_BITS];
		end
	end

	// Shared multiplier operand selection
	logic signed [SAMPLE_WIDTH-1:0] held_left_q, held_right_q;
	logic signed [OPA_WIDTH-1:0]    op_a;
	logic signed [OPB_WIDTH-1:0]    op_b;
	logic signed [PROD_WIDTH-1:0]   prod;

	always_comb begin
		case (ctrl.mul_op)
			OP_DRIVE_L: begin
				op_a = OPA_WIDTH'(left_q);
				op_b = $signed({1'b0, gain_q});
			end
			OP_DRIVE_R: begin
				op_a = OPA_WIDTH'(right_q);
				op_b = $signed({1'b0, gain_q});
			end
			OP_FADE_L: begin
				op_a = OPA_WIDTH'(held_left_q) - OPA_WIDTH'(left_q);
				op_b = $signed(OPB_WIDTH'(mix_q));
			end
			OP_FADE_R: begin
				op_a = OPA_WIDTH'(held_right_q) - OPA_WIDTH'(right_q);
				op_b = $signed(OPB_WIDTH'(mix_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	sbc_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	// Quantizer: round magnitude half away from zero to depth bits, saturate
	logic [DEPTH_WIDTH-1:0]         depth_eff;
	logic [SHIFT_WIDTH-1:0]         rnd_sh, lsb_sh;
	logic                           neg;
	logic [PROD_WIDTH-1:0]          mag, rnd_sum;
	logic [QUOT_WIDTH-1:0]          quot;
	logic                           big;
	logic signed [SAMPLE_WIDTH-1:0] crush_val;

	always_comb begin
		if (bit_depth_q == '0) begin
			depth_eff = DEPTH_WIDTH'(1);
		end else if (bit_depth_q > DEPTH_WIDTH'(QBITS_MAX)) begin
			depth_eff = DEPTH_WIDTH'(QBITS_MAX);
		end else begin
			depth_eff = bit_depth_q;
		end
		rnd_sh  = SHIFT_WIDTH'(SAMPLE_WIDTH + CTRL_WIDTH - 1) - SHIFT_WIDTH'(depth_eff);
		lsb_sh  = SHIFT_WIDTH'(SAMPLE_WIDTH) - SHIFT_WIDTH'(depth_eff);
		neg     = prod[PROD_WIDTH-1];
		mag     = neg ? PROD_WIDTH'(-prod) : PROD_WIDTH'(prod);
		rnd_sum = mag + (PROD_WIDTH'(1) << rnd_sh);
		quot    = rnd_sum[PROD_WIDTH-1:CTRL_WIDTH] & ({QUOT_WIDTH{1'b1}} << lsb_sh);
		big     = |quot[QUOT_WIDTH-1:SAMPLE_WIDTH-1];
		if (neg) begin
			crush_val = big ? SMIN : -$signed(quot[SAMPLE_WIDTH-1:0]);
		end else begin
			crush_val = big ? SMAX : $signed(quot[SAMPLE_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q  <= '0;
			held_right_q <= '0;
		end else begin
			if (ctrl.crush_l && hold_q) held_left_q <= crush_val;
			if (ctrl.crush_r && hold_q) held_right_q <= crush_val;
		end
	end

	// Crossfade: dry + floor((mix*(held-dry) + half) / 2^16), saturated
	logic signed [PROD_WIDTH-1:0]   fade_t, fade_sum;
	logic signed [SAMPLE_WIDTH-1:0] fade_dry, fade_val;

	always_comb begin
		fade_dry = ctrl.fin_l ? left_q : right_q;
		fade_t   = prod + PROD_WIDTH'(1 << (CTRL_WIDTH - 1));
		fade_sum = (fade_t >>> CTRL_WIDTH) + PROD_WIDTH'(fade_dry);
		if (fade_sum > PROD_WIDTH'(SMAX)) begin
			fade_val = SMAX;
		end else if (fade_sum < PROD_WIDTH'(SMIN)) begin
			fade_val = SMIN;
		end else begin
			fade_val = fade_sum[SAMPLE_WIDTH-1:0];
		end
	end

	// Left result waits until the right one is done, then both go out
	logic signed [SAMPLE_WIDTH-1:0] res_left_q;
	logic signed [SAMPLE_WIDTH-1:0] left_out_q, right_out_q;
	logic                           out_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.fin_l) res_left_q <= fade_val;
		if (ctrl.fin_r) begin
			left_out_q  <= res_left_q;
			right_out_q <= fade_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin_r) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// A fresh result only ever comes from the last sequencer step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.fin_r))
		else $error("out_valid rose without final step");

	// An accepted pair starts the drive multiply on the next cycle
	a_acc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (ctrl.mul_en && ctrl.mul_op == OP_DRIVE_L))
		else $error("accepted pair did not start the sequence");

	// Held samples change only in their crush step
	a_held_l: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.crush_l |=> $stable(held_left_q))
		else $error("held_left changed outside crush step");

	a_held_r: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.crush_r |=> $stable(held_right_q))
		else $error("held_right changed outside crush step");

endmodule
